// File: design/assert_macros.svh
// Assertion shorthands, clocked on clock and disabled while reset is high
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent holds in the same cycle as the antecedent
`define DQ_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Consequent holds in the cycle after the antecedent
`define DQ_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: design/dqrm_pkg.sv
package dqrm_pkg;

   localparam int ModeWidth   = 3;
   localparam int ValueWidth  = 64;
   localparam int StatusWidth = 2;

   typedef enum logic [ModeWidth-1:0] {
      OP_PUSH_TAIL = 3'd0,
      OP_PUSH_HEAD = 3'd1,
      OP_POP_HEAD  = 3'd2,
      OP_PEEK_HEAD = 3'd3,
      OP_REMOVE    = 3'd4
   } opcode_type;

   typedef enum logic [StatusWidth-1:0] {
      ST_OK        = 2'd0,
      ST_FULL      = 2'd1,
      ST_EMPTY     = 2'd2,
      ST_NOT_FOUND = 2'd3
   } status_type;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic       load;
      logic       push_tail;
      logic       push_head;
      logic       rd_head;
      logic       take_head;
      logic       pop_head;
      logic       rd_next;
      logic       idx_inc;
      logic       wr_idx;
      logic       count_dec;
      logic       status_we;
      status_type status_code;
   } dp_cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic [ModeWidth-1:0] mode;
      logic                 full;
      logic                 empty;
      logic                 match;
      logic                 last;
   } dp_stat_type;

endpackage

// File: design/dqrm_dp.sv
module dqrm_dp #(
   parameter int QUEUE_DEPTH = 16,
   localparam int CountWidth = $clog2(QUEUE_DEPTH + 1),
   localparam int AddrWidth  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic [dqrm_pkg::ModeWidth-1:0]       req_mode,
   input  logic [dqrm_pkg::ValueWidth-1:0]      req_item_value,
   input  dqrm_pkg::dp_cmd_type                 cmd,
   output dqrm_pkg::dp_stat_type                stat,
   output logic [dqrm_pkg::StatusWidth-1:0]     status,
   output logic [dqrm_pkg::ValueWidth-1:0]      read_value,
   output logic [CountWidth-1:0]                entry_count
);

   localparam int SumWidth = CountWidth + 1;

   logic [dqrm_pkg::ValueWidth-1:0]  entries_ff [QUEUE_DEPTH];
   logic [dqrm_pkg::ValueWidth-1:0]  rdata_ff;
   logic [dqrm_pkg::ValueWidth-1:0]  value_ff, value_in;
   logic [dqrm_pkg::ModeWidth-1:0]   mode_ff, mode_in;
   logic [AddrWidth-1:0]             head_ff, head_in;
   logic [CountWidth-1:0]            count_ff, count_in;
   logic [CountWidth-1:0]            idx_ff, idx_in;
   logic [CountWidth-1:0]            idx_next;
   dqrm_pkg::status_type             status_ff, status_in;
   logic [dqrm_pkg::ValueWidth-1:0]  rval_ff, rval_in;
   logic [AddrWidth-1:0]             head_inc, head_dec;
   logic                             rd_en, wr_en;
   logic [AddrWidth-1:0]             rd_addr, wr_addr;
   logic [dqrm_pkg::ValueWidth-1:0]  wr_data;

   // Map a position counted from the head onto a circular buffer address
   function automatic logic [AddrWidth-1:0] phys(input logic [AddrWidth-1:0]  head,
                                                 input logic [CountWidth-1:0] offset);
      logic [SumWidth-1:0] sum;
      sum = SumWidth'(head) + SumWidth'(offset);
      if (sum >= SumWidth'(QUEUE_DEPTH)) begin
         sum = sum - SumWidth'(QUEUE_DEPTH);
      end
      return sum[AddrWidth-1:0];
   endfunction

   assign idx_next = idx_ff + 1'b1;
   assign head_inc = (head_ff == AddrWidth'(QUEUE_DEPTH - 1)) ? '0 : head_ff + 1'b1;
   assign head_dec = (head_ff == '0) ? AddrWidth'(QUEUE_DEPTH - 1) : head_ff - 1'b1;

   assign rd_en   = cmd.rd_head | cmd.rd_next;
   assign rd_addr = cmd.rd_next ? phys(head_ff, idx_next) : head_ff;
   assign wr_en   = cmd.push_tail | cmd.push_head | cmd.wr_idx;
   assign wr_data = cmd.wr_idx ? rdata_ff : value_ff;

   always_comb begin
      if (cmd.push_head) begin
         wr_addr = head_dec;
      end else if (cmd.wr_idx) begin
         wr_addr = phys(head_ff, idx_ff);
      end else begin
         wr_addr = phys(head_ff, count_ff);
      end
   end

   always_comb begin
      value_in  = value_ff;
      mode_in   = mode_ff;
      head_in   = head_ff;
      count_in  = count_ff;
      idx_in    = idx_ff;
      status_in = status_ff;
      rval_in   = rval_ff;
      if (cmd.load) begin
         value_in  = req_item_value;
         mode_in   = req_mode;
         status_in = dqrm_pkg::ST_OK;
         rval_in   = '0;
      end
      if (cmd.push_head) begin
         head_in = head_dec;
      end else if (cmd.pop_head) begin
         head_in = head_inc;
      end
      if (cmd.push_tail || cmd.push_head) begin
         count_in = count_ff + 1'b1;
      end else if (cmd.pop_head || cmd.count_dec) begin
         count_in = count_ff - 1'b1;
      end
      if (cmd.rd_head) begin
         idx_in = '0;
      end else if (cmd.idx_inc) begin
         idx_in = idx_next;
      end
      if (cmd.status_we) begin
         status_in = cmd.status_code;
      end
      if (cmd.take_head) begin
         rval_in = rdata_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff  <= value_in;
      mode_ff   <= mode_in;
      idx_ff    <= idx_in;
      status_ff <= status_in;
      rval_ff   <= rval_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         entries_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rdata_ff <= entries_ff[rd_addr];
      end
   end

   assign stat.mode  = mode_ff;
   assign stat.full  = (count_ff == CountWidth'(QUEUE_DEPTH));
   assign stat.empty = (count_ff == '0);
   assign stat.match = (rdata_ff == value_ff);
   assign stat.last  = (idx_next >= count_ff);

   assign status      = status_ff;
   assign read_value  = rval_ff;
   assign entry_count = count_ff;

endmodule

// File: design/dqrm_ctrl.sv
module dqrm_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  dqrm_pkg::dp_stat_type stat,
   output logic                  busy,
   output logic                  rsp_strobe,
   output dqrm_pkg::dp_cmd_type  cmd
);

   typedef enum logic [6:0] {
      S_IDLE     = 7'b0000001,
      S_DECODE   = 7'b0000010,
      S_HEAD     = 7'b0000100,
      S_SCAN     = 7'b0001000,
      S_SHIFT_RD = 7'b0010000,
      S_SHIFT_WR = 7'b0100000,
      S_RESP     = 7'b1000000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            state_in = S_RESP;
            case (stat.mode)
               dqrm_pkg::OP_PUSH_TAIL, dqrm_pkg::OP_PUSH_HEAD: begin
                  if (stat.full) begin
                     cmd.status_we   = 1'b1;
                     cmd.status_code = dqrm_pkg::ST_FULL;
                  end else if (stat.mode == dqrm_pkg::OP_PUSH_TAIL) begin
                     cmd.push_tail = 1'b1;
                  end else begin
                     cmd.push_head = 1'b1;
                  end
               end
               dqrm_pkg::OP_POP_HEAD, dqrm_pkg::OP_PEEK_HEAD: begin
                  if (stat.empty) begin
                     cmd.status_we   = 1'b1;
                     cmd.status_code = dqrm_pkg::ST_EMPTY;
                  end else begin
                     cmd.rd_head = 1'b1;
                     state_in    = S_HEAD;
                  end
               end
               dqrm_pkg::OP_REMOVE: begin
                  if (stat.empty) begin
                     cmd.status_we   = 1'b1;
                     cmd.status_code = dqrm_pkg::ST_NOT_FOUND;
                  end else begin
                     cmd.rd_head = 1'b1;
                     state_in    = S_SCAN;
                  end
               end
               default: begin
                  // unused codes: report the level untouched
                  state_in = S_RESP;
               end
            endcase
         end
         S_HEAD: begin
            cmd.take_head = 1'b1;
            cmd.pop_head  = (stat.mode == dqrm_pkg::OP_POP_HEAD);
            state_in      = S_RESP;
         end
         S_SCAN: begin
            if (stat.match) begin
               state_in = S_SHIFT_RD;
            end else if (stat.last) begin
               cmd.status_we   = 1'b1;
               cmd.status_code = dqrm_pkg::ST_NOT_FOUND;
               state_in        = S_RESP;
            end else begin
               cmd.rd_next = 1'b1;
               cmd.idx_inc = 1'b1;
            end
         end
         S_SHIFT_RD: begin
            // close the gap one entry at a time, then drop the tail
            if (stat.last) begin
               cmd.count_dec = 1'b1;
               state_in      = S_RESP;
            end else begin
               cmd.rd_next = 1'b1;
               state_in    = S_SHIFT_WR;
            end
         end
         S_SHIFT_WR: begin
            cmd.wr_idx  = 1'b1;
            cmd.idx_inc = 1'b1;
            state_in    = S_SHIFT_RD;
         end
         S_RESP: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy       = (state_ff != S_IDLE);
   assign rsp_strobe = (state_ff == S_RESP);

endmodule

// File: design/deque_with_remove_by_value_top.sv
// Channel   Handshake                  Payload
// request   start, busy                req_mode, req_item_value
// response  rsp_strobe (one cycle)     rsp_status, rsp_read_value, rsp_entry_count
//
// One operation at a time; entries sit in a circular buffer memory.
// Push, no-op and rejected operations go from decode straight to the response;
// pop and peek first read the head. Remove compares entries from the head one
// at a time; on a hit each later entry is read and then written one place
// toward the head, and then the tail is dropped.
// Reset is synchronous and empties the queue; results cannot be stalled.
`include "assert_macros.svh"

module deque_with_remove_by_value_top #(
   parameter int QUEUE_DEPTH = 16,
   localparam int CountWidth = $clog2(QUEUE_DEPTH + 1)
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic [dqrm_pkg::ModeWidth-1:0]       req_mode,
   input  logic [dqrm_pkg::ValueWidth-1:0]      req_item_value,
   output logic                                 rsp_strobe,
   output logic [dqrm_pkg::StatusWidth-1:0]     rsp_status,
   output logic [dqrm_pkg::ValueWidth-1:0]      rsp_read_value,
   output logic [CountWidth-1:0]                rsp_entry_count
);

   dqrm_pkg::dp_cmd_type  cmd;
   dqrm_pkg::dp_stat_type stat;
   logic                  count_in_range;
   logic                  read_on_ok;

   dqrm_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .stat       (stat),
      .busy       (busy),
      .rsp_strobe (rsp_strobe),
      .cmd        (cmd)
   );

   dqrm_dp #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .req_mode       (req_mode),
      .req_item_value (req_item_value),
      .cmd            (cmd),
      .stat           (stat),
      .status         (rsp_status),
      .read_value     (rsp_read_value),
      .entry_count    (rsp_entry_count)
   );

   assign count_in_range = (rsp_entry_count <= CountWidth'(QUEUE_DEPTH));
   assign read_on_ok     = (rsp_read_value == '0) || (rsp_status == dqrm_pkg::ST_OK);

   `DQ_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted beat did not raise busy")
   `DQ_ASSERT_NEXT(a_single_rsp, rsp_strobe, !rsp_strobe, "response strobe held past one cycle")
   `DQ_ASSERT_SAME(a_rsp_in_op, rsp_strobe, busy, "response outside an operation")
   `DQ_ASSERT_SAME(a_count_bound, rsp_strobe, count_in_range, "entry count above depth")
   `DQ_ASSERT_SAME(a_read_ok, rsp_strobe, read_on_ok, "read data on a failed operation")

endmodule

// File: tb/tb.sv
module tb;
   import dqrm_pkg::*;

   localparam int QDEPTH        = 16;
   localparam int CNT_W         = $clog2(QDEPTH + 1);
   localparam int VAL_W         = ValueWidth;
   localparam int CYCLE_LIMIT   = 500000;
   localparam int RANDOM_OPS    = 1026;
   localparam int BIAS_SPAN     = 50;
   localparam int SETTLE_CYCLES = 60;
   localparam int REPORT_MAX    = 10;
   localparam logic [ModeWidth-1:0] MODE_SPARE_LO = ModeWidth'(OP_REMOVE) + 1'b1;
   localparam logic [ModeWidth-1:0] MODE_SPARE_HI = '1;

   typedef struct packed {
      logic [StatusWidth-1:0] status;
      logic [VAL_W-1:0]       value;
      logic [CNT_W-1:0]       count;
   } op_result_type;

   class deque_scoreboard;
      logic [VAL_W-1:0] held[$];
      op_result_type    awaited[$];
      int unsigned      mismatches;
      int unsigned      ops_noted;
      int unsigned      results_seen;
      int unsigned      peak_fill;
      int unsigned      status_seen[4];

      function void note_request(logic [ModeWidth-1:0] mode, logic [VAL_W-1:0] value);
         op_result_type r;
         int pos;
         r.status = ST_OK;
         r.value = '0;
         pos = -1;
         case (mode)
            OP_PUSH_TAIL: begin
               if (held.size() >= QDEPTH) r.status = ST_FULL;
               else held.push_back(value);
            end
            OP_PUSH_HEAD: begin
               if (held.size() >= QDEPTH) r.status = ST_FULL;
               else held.push_front(value);
            end
            OP_POP_HEAD: begin
               if (held.size() == 0) r.status = ST_EMPTY;
               else r.value = held.pop_front();
            end
            OP_PEEK_HEAD: begin
               if (held.size() == 0) r.status = ST_EMPTY;
               else r.value = held[0];
            end
            OP_REMOVE: begin
               // only the match nearest the head goes
               for (int i = 0; i < held.size(); i++)
                  if (pos < 0 && held[i] == value) pos = i;
               if (pos < 0) r.status = ST_NOT_FOUND;
               else held.delete(pos);
            end
            default: begin
            end
         endcase
         r.count = CNT_W'(held.size());
         if (held.size() > peak_fill) peak_fill = held.size();
         status_seen[r.status]++;
         ops_noted++;
         awaited.push_back(r);
      endfunction

      function void check_result(logic [StatusWidth-1:0] status, logic [VAL_W-1:0] value,
                                 logic [CNT_W-1:0] count);
         op_result_type want;
         if (awaited.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_MAX)
               $display("unexpected result: status %0d value %h count %0d",
                        status, value, count);
         end else begin
            want = awaited.pop_front();
            results_seen++;
            if (want.status !== status || want.value !== value || want.count !== count) begin
               mismatches++;
               if (mismatches <= REPORT_MAX)
                  $display("result %0d mismatch: status %0d/%0d value %h/%h count %0d/%0d",
                           results_seen, want.status, status, want.value, value,
                           want.count, count);
            end
         end
      endfunction
   endclass

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   start;
   logic                   busy;
   logic [ModeWidth-1:0]   req_mode;
   logic [VAL_W-1:0]       req_item_value;
   logic                   rsp_strobe;
   logic [StatusWidth-1:0] rsp_status;
   logic [VAL_W-1:0]       rsp_read_value;
   logic [CNT_W-1:0]       rsp_entry_count;

   deque_scoreboard sb = new();
   int unsigned     idle_pct;
   int unsigned     cycles;

   deque_with_remove_by_value_top #(.QUEUE_DEPTH(QDEPTH)) u_top (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_mode        (req_mode),
      .req_item_value  (req_item_value),
      .rsp_strobe      (rsp_strobe),
      .rsp_status      (rsp_status),
      .rsp_read_value  (rsp_read_value),
      .rsp_entry_count (rsp_entry_count)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      if (!reset && rsp_strobe)
         sb.check_result(rsp_status, rsp_read_value, rsp_entry_count);
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // Handles that recur, so removes meet duplicates and every bit toggles
   function automatic logic [VAL_W-1:0] handle_from_pool(int unsigned k);
      case (k % 6)
         0: handle_from_pool = '1;
         1: handle_from_pool = '0;
         2: handle_from_pool = {(VAL_W/2){2'b01}};
         3: handle_from_pool = {(VAL_W/2){2'b10}};
         4: handle_from_pool = VAL_W'(1);
         default: handle_from_pool = {1'b1, {(VAL_W-1){1'b0}}};
      endcase
   endfunction

   function automatic logic [VAL_W-1:0] random_handle();
      random_handle = {$urandom, $urandom};
   endfunction

   task automatic send_op(input logic [ModeWidth-1:0] mode, input logic [VAL_W-1:0] value);
      while ($urandom_range(99) < idle_pct) begin
         @(negedge clock);
         start <= 1'b0;
      end
      @(negedge clock);
      start          <= 1'b1;
      req_mode       <= mode;
      req_item_value <= value;
      @(posedge clock);
      while (busy) @(posedge clock);
      sb.note_request(mode, value);
   endtask

   // Hold off until every outstanding result has come back
   task automatic drain_queue();
      @(negedge clock);
      start <= 1'b0;
      while (sb.awaited.size() != 0) @(posedge clock);
   endtask

   task automatic random_op(input bit filling);
      int unsigned r;
      int unsigned pick;
      int unsigned cut_tail, cut_head, cut_pop, cut_peek;
      logic [ModeWidth-1:0] mode;
      logic [VAL_W-1:0] value;
      r = $urandom_range(99);
      pick = $urandom_range(99);
      if (filling) begin
         cut_tail = 36; cut_head = 68; cut_pop = 80; cut_peek = 87;
      end else begin
         cut_tail = 15; cut_head = 25; cut_pop = 60; cut_peek = 70;
      end
      if (r < 3) mode = ModeWidth'($urandom_range(MODE_SPARE_LO, MODE_SPARE_HI));
      else if (r < cut_tail) mode = OP_PUSH_TAIL;
      else if (r < cut_head) mode = OP_PUSH_HEAD;
      else if (r < cut_pop) mode = OP_POP_HEAD;
      else if (r < cut_peek) mode = OP_PEEK_HEAD;
      else mode = OP_REMOVE;

      if (mode == OP_REMOVE && pick < 60 && sb.held.size() > 0)
         value = sb.held[$urandom_range(0, sb.held.size() - 1)];
      else if (pick < 80 && pick >= 50)
         value = handle_from_pool($urandom_range(0, 5));
      else
         value = random_handle();
      send_op(mode, value);
   endtask

   initial begin
      reset          = 1'b1;
      start          = 1'b0;
      req_mode       = '0;
      req_item_value = '0;
      idle_pct       = 0;
      cycles         = 0;
      repeat (8) @(negedge clock);
      reset <= 1'b0;

      // empty queue corner cases and spare mode codes
      send_op(OP_POP_HEAD, '0);
      send_op(OP_PEEK_HEAD, '1);
      send_op(OP_REMOVE, '0);
      send_op(MODE_SPARE_LO, '1);
      send_op(MODE_SPARE_HI, '0);

      // fill to the brim from both ends, with repeated handles
      for (int i = 0; i < QDEPTH; i++)
         send_op((i % 2 == 0) ? OP_PUSH_TAIL : OP_PUSH_HEAD,
                 (i < 6) ? handle_from_pool(i) :
                 (i < 10) ? handle_from_pool(2) : random_handle());
      send_op(OP_PUSH_TAIL, random_handle());
      send_op(OP_PUSH_HEAD, random_handle());
      send_op(OP_PEEK_HEAD, '0);
      send_op(OP_REMOVE, handle_from_pool(2));
      send_op(OP_REMOVE, random_handle());
      send_op(OP_POP_HEAD, '1);

      for (int phase = 0; phase < 3; phase++) begin
         drain_queue();
         case (phase)
            0: idle_pct = 0;
            1: idle_pct = 78;
            default: idle_pct = 30;
         endcase
         for (int n = 0; n < RANDOM_OPS / 3; n++)
            random_op((n / BIAS_SPAN) % 2 == 0);
      end

      drain_queue();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (sb.awaited.size() != 0) begin
         $display("%0d results never arrived", sb.awaited.size());
         sb.mismatches += sb.awaited.size();
      end

      $display("%0d operations driven, %0d results checked, peak fill %0d of %0d",
               sb.ops_noted, sb.results_seen, sb.peak_fill, QDEPTH);
      $display("outcomes: ok %0d, full %0d, empty %0d, not found %0d; %0d mismatches",
               sb.status_seen[ST_OK], sb.status_seen[ST_FULL], sb.status_seen[ST_EMPTY],
               sb.status_seen[ST_NOT_FOUND], sb.mismatches);
      if (sb.mismatches == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule
